// ===== rtl/core/mclp_pkg.sv =====
`default_nettype none
package mclp_pkg;

  // bytes of one line that are looked at
  localparam int unsigned LINE_CAPACITY = 63;
  localparam int unsigned COUNT_W = $clog2(LINE_CAPACITY + 1);

  localparam logic [7:0] CH_NUL   = 8'd0;
  localparam logic [7:0] CH_TAB   = 8'd9;
  localparam logic [7:0] CH_LF    = 8'd10;
  localparam logic [7:0] CH_VT    = 8'd11;
  localparam logic [7:0] CH_FF    = 8'd12;
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_SPACE = 8'd32;
  localparam logic [7:0] CH_PLUS  = 8'd43;
  localparam logic [7:0] CH_MINUS = 8'd45;
  localparam logic [7:0] CH_ZERO  = 8'd48;
  localparam logic [7:0] CH_NINE  = 8'd57;
  localparam logic [7:0] CH_E     = 8'd69;
  localparam logic [7:0] CH_H     = 8'd72;
  localparam logic [7:0] CH_M     = 8'd77;
  localparam logic [7:0] CH_O     = 8'd79;
  localparam logic [7:0] CH_R     = 8'd82;
  localparam logic [7:0] CH_X     = 8'd88;
  localparam logic [7:0] CH_Y     = 8'd89;

  localparam logic [31:0] MAG_CAP = 32'h8000_0000;
  localparam logic [31:0] POS_MAX = 32'h7fff_ffff;

  typedef enum logic [2:0] {
    CLS_OTHER = 3'd0,
    CLS_H     = 3'd1,
    CLS_HO    = 3'd2,
    CLS_HOM   = 3'd3,
    CLS_HOME  = 3'd4,
    CLS_E     = 3'd5,
    CLS_X     = 3'd6,
    CLS_R     = 3'd7
  } line_class_t;

  typedef enum logic [1:0] {
    PH_LEAD   = 2'd0,
    PH_DIGITS = 2'd1,
    PH_DONE   = 2'd2
  } phase_t;

  typedef enum logic [2:0] {
    CMD_IGNORED = 3'd0,
    CMD_HOME    = 3'd1,
    CMD_ESTOP   = 3'd2,
    CMD_MOVE    = 3'd3,
    CMD_RESET   = 3'd4
  } command_t;

  typedef struct packed {
    phase_t      phase;
    logic        negative;
    logic [31:0] magnitude;
  } reader_t;

  localparam reader_t READER_CLEAR = '{phase: PH_LEAD, negative: 1'b0, magnitude: 32'd0};

endpackage
`default_nettype wire

// ===== rtl/core/motion_command_line_parser_unit.sv =====
// result: a line terminator that ends a non-empty line loads its command into the result
//   register, visible in the cycle after its transfer; other bytes produce no result
// throughput: one byte per cycle; input stalls only while a held result is stalled
// reset: rst is synchronous and active high; it clears the line state and the result
//   valid flag (not the payload), no clearing pass is needed
`default_nettype none
module motion_command_line_parser_unit
  import mclp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  rx_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [2:0]       command,
  output logic [31:0]      move_x,
  output logic [31:0]      move_y
);

  // atoi step: blanks, one sign, then decimal digits with saturation at 2^31
  function automatic reader_t reader_feed(input reader_t r, input logic [7:0] c);
    reader_t     n;
    logic [34:0] m;
    logic        digit;
    n     = r;
    digit = (c >= CH_ZERO) && (c <= CH_NINE);
    // magnitude * 10 as two shifted adds
    m = {r.magnitude, 3'b000} + {2'b00, r.magnitude, 1'b0} + {27'd0, c - CH_ZERO};
    if (r.phase != PH_DONE) begin
      if (digit) begin
        n.magnitude = (m > {3'b000, MAG_CAP}) ? MAG_CAP : m[31:0];
        n.phase     = PH_DIGITS;
      end else if ((r.phase == PH_LEAD) &&
                   ((c == CH_SPACE) || (c == CH_TAB) || (c == CH_VT) || (c == CH_FF))) begin
        n.phase = PH_LEAD;
      end else if ((r.phase == PH_LEAD) && ((c == CH_PLUS) || (c == CH_MINUS))) begin
        n.negative = (c == CH_MINUS);
        n.phase    = PH_DIGITS;
      end else begin
        n.phase = PH_DONE;
      end
    end
    return n;
  endfunction

  function automatic logic [31:0] reader_value(input reader_t r);
    logic [31:0] v;
    if (r.negative) begin
      v = 32'd0 - r.magnitude;
    end else begin
      v = (r.magnitude > POS_MAX) ? POS_MAX : r.magnitude;
    end
    return v;
  endfunction

  // line state
  logic [COUNT_W-1:0] stored_count, stored_count_next;
  line_class_t        line_class, line_class_next;
  logic               text_ended, text_ended_next;
  reader_t            x_reader, x_reader_next;
  logic               y_found, y_found_next;
  reader_t            y_reader, y_reader_next;

  // result register
  command_t    command_reg, command_next;
  logic [31:0] move_x_reg, move_x_next;
  logic [31:0] move_y_reg, move_y_next;
  logic        emit;

  logic accept;
  logic is_term;
  logic first_byte;

  // a held result only blocks input while the sink stalls it
  assign in_stall   = out_valid && out_stall;
  assign accept     = in_valid && !in_stall;
  assign is_term    = (rx_byte == CH_LF) || (rx_byte == CH_CR);
  assign first_byte = (stored_count == '0);

  always_comb begin
    stored_count_next = stored_count;
    line_class_next   = line_class;
    text_ended_next   = text_ended;
    x_reader_next     = x_reader;
    y_found_next      = y_found;
    y_reader_next     = y_reader;
    emit              = 1'b0;
    command_next      = CMD_IGNORED;
    move_x_next       = 32'd0;
    move_y_next       = 32'd0;

    if (is_term) begin
      // end of line: emit for a non-empty line, then clear the line state
      emit = !first_byte;
      unique case (line_class)
        CLS_HOME: command_next = CMD_HOME;
        CLS_E:    command_next = CMD_ESTOP;
        CLS_X: begin
          command_next = CMD_MOVE;
          move_x_next  = reader_value(x_reader);
          move_y_next  = y_found ? reader_value(y_reader) : 32'd0;
        end
        CLS_R:    command_next = CMD_RESET;
        default:  command_next = CMD_IGNORED;
      endcase
      stored_count_next = '0;
      line_class_next   = CLS_OTHER;
      text_ended_next   = 1'b0;
      x_reader_next     = READER_CLEAR;
      y_found_next      = 1'b0;
      y_reader_next     = READER_CLEAR;
    end else if (stored_count < COUNT_W'(LINE_CAPACITY)) begin
      stored_count_next = stored_count + 1'b1;
      if (!text_ended) begin
        if (rx_byte == CH_NUL) begin
          // zero byte ends the text; an unfinished HOME prefix falls back
          text_ended_next = 1'b1;
          if (first_byte || (line_class == CLS_H) || (line_class == CLS_HO) ||
              (line_class == CLS_HOM)) begin
            line_class_next = CLS_OTHER;
          end
        end else begin
          if (first_byte) begin
            unique case (rx_byte)
              CH_H:    line_class_next = CLS_H;
              CH_E:    line_class_next = CLS_E;
              CH_X:    line_class_next = CLS_X;
              CH_R:    line_class_next = CLS_R;
              default: line_class_next = CLS_OTHER;
            endcase
          end else begin
            unique case (line_class)
              CLS_H:   line_class_next = (rx_byte == CH_O) ? CLS_HO : CLS_OTHER;
              CLS_HO:  line_class_next = (rx_byte == CH_M) ? CLS_HOM : CLS_OTHER;
              CLS_HOM: line_class_next = (rx_byte == CH_E) ? CLS_HOME : CLS_OTHER;
              default: line_class_next = line_class;
            endcase
            x_reader_next = reader_feed(x_reader, rx_byte);
          end
          // the y reader starts on the byte after the first Y
          if (y_found) begin
            y_reader_next = reader_feed(y_reader, rx_byte);
          end else if (rx_byte == CH_Y) begin
            y_found_next = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stored_count <= '0;
      line_class   <= CLS_OTHER;
      text_ended   <= 1'b0;
      x_reader     <= READER_CLEAR;
      y_found      <= 1'b0;
      y_reader     <= READER_CLEAR;
      out_valid    <= 1'b0;
    end else begin
      if (accept) begin
        stored_count <= stored_count_next;
        line_class   <= line_class_next;
        text_ended   <= text_ended_next;
        x_reader     <= x_reader_next;
        y_found      <= y_found_next;
        y_reader     <= y_reader_next;
      end
      // result register: load on a new command, drop when the sink takes it
      if (accept && emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // result payload, loaded only with a new command
  always_ff @(posedge clk) begin
    if (accept && emit) begin
      command_reg <= command_next;
      move_x_reg  <= move_x_next;
      move_y_reg  <= move_y_next;
    end
  end

  assign command = command_reg;
  assign move_x  = move_x_reg;
  assign move_y  = move_y_reg;

endmodule
`default_nettype wire
